>>> rtl/rrd_pkg.sv
// Package for the raster row decompressor: payload structs, operation codes,
// parse phase codes and compression mode codes. No dependencies.
package rrd_pkg;

    localparam logic [1:0] OP_DATA  = 2'd0;
    localparam logic [1:0] OP_END   = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;
    localparam logic [1:0] OP_CLEAR = 2'd3;

    localparam logic [1:0] MODE_RAW   = 2'd0;
    localparam logic [1:0] MODE_RUN   = 2'd1;
    localparam logic [1:0] MODE_PACK  = 2'd2;
    localparam logic [1:0] MODE_DELTA = 2'd3;

    localparam logic [2:0] PH_CONTROL = 3'd0;
    localparam logic [2:0] PH_FILL    = 3'd1;
    localparam logic [2:0] PH_LITERAL = 3'd2;
    localparam logic [2:0] PH_REPEAT  = 3'd3;
    localparam logic [2:0] PH_EXTEND  = 3'd4;
    localparam logic [2:0] PH_COPY    = 3'd5;

    localparam logic CFG_MODE = 1'b0;
    localparam logic CFG_ROW  = 1'b1;

    typedef struct packed {
        logic [1:0]  operation;
        logic [7:0]  data_byte;
        logic [10:0] read_index;
    } t_in_item;

    typedef struct packed {
        logic [7:0]  read_byte;
        logic [11:0] row_length;
        logic        row_empty;
        logic        bad_length;
    } t_out_item;

    // Write request from the decoder to the seed memory.
    typedef struct packed {
        logic        wr_en;
        logic [15:0] wr_addr;
        logic [7:0]  wr_data;
    } t_seed_wr;

endpackage

>>> rtl/rrd_seed_mem.sv
// Seed row memory: one write port, one registered read port, with a
// clearing pass after reset. Depends on rrd_pkg.
module rrd_seed_mem #(
    parameter int DEPTH = 2048,
    parameter int AW    = 11
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rrd_pkg::t_seed_wr i_wr,
    input  logic [AW-1:0]     i_rd_addr,
    output logic [7:0]        o_rd_data,
    output logic              o_clearing
);
    import rrd_pkg::*;

    logic [7:0]  r_mem [DEPTH];
    logic [AW:0] r_clr_addr;
    logic        r_clearing;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
            r_clearing <= 1'b1;
        end else if (r_clearing) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == (AW+1)'(DEPTH - 1)) begin
                r_clearing <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clearing) begin
            r_mem[r_clr_addr[AW-1:0]] <= 8'd0;
        end else if (i_wr.wr_en) begin
            r_mem[i_wr.wr_addr[AW-1:0]] <= i_wr.wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

    assign o_clearing = r_clearing;

endmodule

>>> rtl/raster_row_decompressor.sv
// Raster row decompressor (modes 0 to 3) into a seed row memory.
// Takes one item per cycle while busy is low: a run of n bytes (modes 1
// and 2) keeps busy high while the memory write port places one byte a
// cycle, and a read item keeps busy high while it passes through the
// registered memory port. After reset busy stays high while the seed memory
// is cleared. Results appear for one cycle on o_result with o_result_valid;
// they cannot be stalled.
module raster_row_decompressor #(
    parameter int MAX_ROW_BYTES = 2048
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  rrd_pkg::t_in_item i_item,
    output logic              o_result_valid,
    output rrd_pkg::t_out_item o_result,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic              i_cfg_index,
    input  logic [11:0]       i_cfg_data
);
    import rrd_pkg::*;

    localparam int AW = $clog2(MAX_ROW_BYTES);
    localparam int PW = AW + 1;

    logic [1:0]  r_mode;
    logic [11:0] r_row_bytes;
    logic [PW-1:0] r_pos, n_pos;
    logic [PW-1:0] r_count, n_count;
    logic        r_empty, n_empty;
    logic [2:0]  r_phase, n_phase;
    logic [8:0]  r_pend, n_pend;
    logic [11:0] r_off, n_off;
    logic        r_parity, n_parity;
    logic [8:0]  r_run, n_run;
    logic [7:0]  r_run_byte, n_run_byte;
    logic        r_rd_pend;
    logic        r_res_valid, n_res_valid;
    t_out_item   r_res, n_res;
    logic        r_rd_fwd;

    t_seed_wr    seed_wr;
    logic [7:0]  rd_data;
    logic        clearing;
    logic        accept;
    logic [PW-1:0] lim;
    logic        can_put;

    rrd_seed_mem #(.DEPTH(MAX_ROW_BYTES), .AW(AW)) u_mem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr       (seed_wr),
        .i_rd_addr  (AW'(i_item.read_index)),
        .o_rd_data  (rd_data),
        .o_clearing (clearing)
    );

    assign busy        = clearing || (r_run != 9'd0) || r_rd_pend;
    assign accept      = start && !busy;
    assign o_cfg_ready = 1'b1;
    assign lim = (32'(r_row_bytes) < MAX_ROW_BYTES) ? PW'(r_row_bytes)
                                                    : PW'(MAX_ROW_BYTES);
    assign can_put = r_pos < lim;

    function automatic logic [PW-1:0] skip_to(input logic [PW-1:0] pos,
                                              input logic [PW-1:0] limit,
                                              input logic [11:0] skip);
        logic [16:0] sum;
        begin
            sum = 17'(pos) + 17'(skip);
            if (pos >= limit) begin
                skip_to = pos;
            end else if (sum >= 17'(limit)) begin
                skip_to = limit;
            end else begin
                skip_to = PW'(sum);
            end
        end
    endfunction

    always_comb begin
        logic [7:0]  b;
        logic [12:0] osum;
        logic [PW-1:0] pos_e;
        b          = i_item.data_byte;
        osum       = '0;
        pos_e      = r_pos;
        n_pos      = r_pos;
        n_count    = r_count;
        n_empty    = r_empty;
        n_phase    = r_phase;
        n_pend     = r_pend;
        n_off      = r_off;
        n_parity   = r_parity;
        n_run      = r_run;
        n_run_byte = r_run_byte;
        n_res_valid = 1'b0;
        n_res      = r_res;
        seed_wr    = '0;
        seed_wr.wr_addr = 16'(r_pos);
        if (r_run != 9'd0) begin
            if (can_put) begin
                seed_wr.wr_en   = 1'b1;
                seed_wr.wr_data = r_run_byte;
                n_pos           = r_pos + 1'b1;
            end
            n_run = r_run - 1'b1;
        end else if (accept) begin
            case (i_item.operation)
                OP_DATA: begin
                    seed_wr.wr_data = b;
                    case (r_mode)
                        MODE_RAW: begin
                            if (can_put) begin
                                seed_wr.wr_en = 1'b1;
                                n_pos = r_pos + 1'b1;
                            end
                        end
                        MODE_RUN: begin
                            n_parity = !r_parity;
                            if (r_phase == PH_FILL) begin
                                n_run      = r_pend;
                                n_run_byte = b;
                                n_phase    = PH_CONTROL;
                            end else begin
                                n_pend  = 9'(b) + 9'd1;
                                n_phase = PH_FILL;
                            end
                        end
                        MODE_PACK: begin
                            if (r_phase == PH_LITERAL) begin
                                if (can_put) begin
                                    seed_wr.wr_en = 1'b1;
                                    n_pos = r_pos + 1'b1;
                                end
                                if (r_pend <= 9'd1) begin
                                    n_pend  = 9'd0;
                                    n_phase = PH_CONTROL;
                                end else begin
                                    n_pend = r_pend - 1'b1;
                                end
                            end else if (r_phase == PH_REPEAT) begin
                                n_run      = r_pend;
                                n_run_byte = b;
                                n_phase    = PH_CONTROL;
                            end else if (b < 8'd128) begin
                                n_pend  = 9'(b) + 9'd1;
                                n_phase = PH_LITERAL;
                            end else if (b > 8'd128) begin
                                n_pend  = 9'd257 - 9'(b);
                                n_phase = PH_REPEAT;
                            end else begin
                                n_phase = PH_CONTROL;
                            end
                        end
                        default: begin
                            if (r_phase == PH_COPY) begin
                                if (can_put) begin
                                    seed_wr.wr_en = 1'b1;
                                    n_pos = r_pos + 1'b1;
                                end
                                if (r_pend <= 9'd1) begin
                                    n_pend  = 9'd0;
                                    n_phase = PH_CONTROL;
                                end else begin
                                    n_pend = r_pend - 1'b1;
                                end
                            end else if (r_phase == PH_EXTEND) begin
                                osum  = 13'(r_off) + 13'(b);
                                n_off = osum[12] ? 12'hFFF : osum[11:0];
                                if (b != 8'd255) begin
                                    n_pos   = skip_to(r_pos, lim, n_off);
                                    n_off   = '0;
                                    n_phase = PH_COPY;
                                end
                            end else begin
                                n_pend = 9'(b[7:5]) + 9'd1;
                                if (b[4:0] == 5'd31) begin
                                    n_off   = 12'd31;
                                    n_phase = PH_EXTEND;
                                end else begin
                                    n_pos   = skip_to(r_pos, lim, 12'(b[4:0]));
                                    n_phase = PH_COPY;
                                end
                            end
                        end
                    endcase
                end
                OP_END: begin
                    n_res_valid    = 1'b1;
                    n_res.read_byte  = 8'd0;
                    n_res.bad_length = 1'b0;
                    if (r_mode == MODE_DELTA) begin
                        if (r_phase == PH_EXTEND) begin
                            pos_e = skip_to(r_pos, lim, r_off);
                        end
                        if (pos_e > r_count) begin
                            n_count = pos_e;
                        end
                        if (pos_e != '0) begin
                            n_empty = 1'b0;
                        end
                    end else if (r_mode == MODE_RUN && r_parity) begin
                        n_res.bad_length = 1'b1;
                        n_count = '0;
                        n_empty = 1'b1;
                    end else begin
                        n_count = r_pos;
                        n_empty = (r_pos == '0);
                    end
                    n_res.row_length = 12'(n_count);
                    n_res.row_empty  = n_empty;
                    n_pos    = '0;
                    n_phase  = PH_CONTROL;
                    n_pend   = '0;
                    n_off    = '0;
                    n_parity = 1'b0;
                end
                OP_CLEAR: begin
                    n_count = '0;
                    n_empty = 1'b1;
                end
                default: begin
                end
            endcase
        end
        if (r_rd_pend) begin
            n_res_valid      = 1'b1;
            n_res.read_byte  = r_rd_fwd ? rd_data : 8'd0;
            n_res.row_length = 12'(r_count);
            n_res.row_empty  = r_empty;
            n_res.bad_length = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_RAW;
            r_row_bytes <= '0;
            r_pos       <= '0;
            r_count     <= '0;
            r_empty     <= 1'b1;
            r_phase     <= PH_CONTROL;
            r_pend      <= '0;
            r_off       <= '0;
            r_parity    <= 1'b0;
            r_run       <= '0;
            r_rd_pend   <= 1'b0;
            r_res_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_empty     <= n_empty;
            r_run       <= n_run;
            r_res_valid <= n_res_valid;
            r_rd_pend   <= accept && (i_item.operation == OP_READ);
            if (i_cfg_valid && i_cfg_index == CFG_MODE) begin
                r_mode   <= i_cfg_data[1:0];
                r_pos    <= '0;
                r_phase  <= PH_CONTROL;
                r_pend   <= '0;
                r_off    <= '0;
                r_parity <= 1'b0;
            end else begin
                r_pos    <= n_pos;
                r_phase  <= n_phase;
                r_pend   <= n_pend;
                r_off    <= n_off;
                r_parity <= n_parity;
            end
            if (i_cfg_valid && i_cfg_index == CFG_ROW) begin
                r_row_bytes <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_res      <= n_res;
        r_run_byte <= n_run_byte;
        r_rd_fwd   <= 32'(i_item.read_index) < MAX_ROW_BYTES;
    end

    assign o_result_valid = r_res_valid;
    assign o_result       = r_res;

endmodule

>>> rtl/rrd_checker.sv
// Port level checks for the raster row decompressor, bound to the top level.
// Depends on rrd_pkg.
module rrd_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              start,
    input logic              busy,
    input rrd_pkg::t_in_item i_item,
    input logic              o_result_valid,
    input rrd_pkg::t_out_item o_result
);
    import rrd_pkg::*;

    a_read_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_item.operation == OP_READ) |=> ##1 o_result_valid)
        else $error("read beat gave no result");

    a_read_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_item.operation == OP_READ) |=> busy)
        else $error("busy low during read");

    a_end_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_item.operation == OP_END) |=> o_result_valid)
        else $error("end beat gave no result");

    a_bad_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_result.bad_length) |->
            (o_result.row_empty && o_result.row_length == 12'd0))
        else $error("bad length result not empty");

endmodule

bind raster_row_decompressor rrd_checker u_rrd_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .i_item         (i_item),
    .o_result_valid (o_result_valid),
    .o_result       (o_result)
);

>>> tb/raster_row_decompressor_tb.sv
// Self-checking testbench for the raster row decompressor: directed rows in
// every compression mode, then random transfers under three sender idle mixes.
// Depends on rrd_pkg and the raster_row_decompressor RTL.
`timescale 1ns / 1ps

module raster_row_decompressor_tb;

    import rrd_pkg::*;

    localparam int SEED_DEPTH  = 2048;
    localparam int CYCLE_LIMIT = 3000000;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    t_in_item    i_item;
    logic        o_result_valid;
    t_out_item   o_result;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic        i_cfg_index;
    logic [11:0] i_cfg_data;

    raster_row_decompressor dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_item         (i_item),
        .o_result_valid (o_result_valid),
        .o_result       (o_result),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    logic [7:0]  seed_copy [SEED_DEPTH];
    logic [1:0]  cur_mode;
    int unsigned cur_row_bytes;
    int unsigned wr_pos;
    int unsigned row_cnt;
    logic        row_void;
    logic [2:0]  phase;
    int unsigned pending;
    int unsigned offset_acc;
    logic        parity;

    t_out_item   pending_results [$];
    int          errors;
    int          beats_sent;
    int          results_seen;
    int          idle_pct;
    longint      cycles;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int unsigned row_limit();
        return (cur_row_bytes < SEED_DEPTH) ? cur_row_bytes : SEED_DEPTH;
    endfunction

    task automatic restart_row();
        wr_pos     = 0;
        phase      = PH_CONTROL;
        pending    = 0;
        offset_acc = 0;
        parity     = 1'b0;
    endtask

    task automatic place_byte(input logic [7:0] b);
        if (wr_pos < row_limit()) begin
            seed_copy[wr_pos] = b;
            wr_pos++;
        end
    endtask

    task automatic place_run(input logic [7:0] b, input int unsigned n);
        repeat (n) place_byte(b);
    endtask

    task automatic skip_ahead(input int unsigned skip);
        int unsigned lim;
        lim = row_limit();
        if (wr_pos < lim)
            wr_pos = (lim - wr_pos < skip) ? lim : wr_pos + skip;
    endtask

    task automatic decode_byte(input logic [7:0] b);
        case (cur_mode)
            MODE_RAW: begin
                place_byte(b);
            end
            MODE_RUN: begin
                parity = ~parity;
                if (phase == PH_FILL) begin
                    place_run(b, pending);
                    phase = PH_CONTROL;
                end else begin
                    pending = b + 1;
                    phase   = PH_FILL;
                end
            end
            MODE_PACK: begin
                if (phase == PH_LITERAL) begin
                    place_byte(b);
                    if (pending > 0) pending--;
                    if (pending == 0) phase = PH_CONTROL;
                end else if (phase == PH_REPEAT) begin
                    place_run(b, pending);
                    phase = PH_CONTROL;
                end else if (b < 128) begin
                    pending = b + 1;
                    phase   = PH_LITERAL;
                end else if (b > 128) begin
                    pending = 257 - b;
                    phase   = PH_REPEAT;
                end else begin
                    phase = PH_CONTROL;
                end
            end
            default: begin
                if (phase == PH_COPY) begin
                    place_byte(b);
                    if (pending > 0) pending--;
                    if (pending == 0) phase = PH_CONTROL;
                end else if (phase == PH_EXTEND) begin
                    offset_acc += b;
                    if (offset_acc > 4095) offset_acc = 4095;
                    if (b != 8'hFF) begin
                        skip_ahead(offset_acc);
                        offset_acc = 0;
                        phase      = PH_COPY;
                    end
                end else begin
                    pending = b[7:5] + 1;
                    if (b[4:0] == 5'd31) begin
                        offset_acc = 31;
                        phase      = PH_EXTEND;
                    end else begin
                        skip_ahead(b[4:0]);
                        phase = PH_COPY;
                    end
                end
            end
        endcase
    endtask

    task automatic predict_row_op(input t_in_item it);
        t_out_item r;
        r = '0;
        case (it.operation)
            OP_DATA: begin
                decode_byte(it.data_byte);
            end
            OP_CLEAR: begin
                row_cnt  = 0;
                row_void = 1'b1;
            end
            OP_READ: begin
                r.read_byte  = seed_copy[it.read_index];
                r.row_length = row_cnt[11:0];
                r.row_empty  = row_void;
                pending_results.push_back(r);
            end
            default: begin
                if (cur_mode == MODE_DELTA) begin
                    if (phase == PH_EXTEND) skip_ahead(offset_acc);
                    if (wr_pos > row_cnt) row_cnt = wr_pos;
                    if (wr_pos != 0) row_void = 1'b0;
                end else if (cur_mode == MODE_RUN && parity) begin
                    r.bad_length = 1'b1;
                    row_cnt      = 0;
                    row_void     = 1'b1;
                end else begin
                    row_cnt  = wr_pos;
                    row_void = (wr_pos == 0);
                end
                restart_row();
                r.row_length = row_cnt[11:0];
                r.row_empty  = row_void;
                pending_results.push_back(r);
            end
        endcase
    endtask

    task automatic check_field(input string name, input int exp_v, input int act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, exp_v, act_v);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycles);
            $display("simulation failed");
            $finish;
        end else if (i_rst_n && o_result_valid) begin
            results_seen <= results_seen + 1;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result, expected none actual %p", $time, o_result);
                errors++;
            end else begin
                want = pending_results.pop_front();
                check_field("read_byte", want.read_byte, o_result.read_byte);
                check_field("row_length", want.row_length, o_result.row_length);
                check_field("row_empty", want.row_empty, o_result.row_empty);
                check_field("bad_length", want.bad_length, o_result.bad_length);
            end
        end
    end

    task automatic send_item(input logic [1:0] op, input logic [7:0] b,
                             input logic [10:0] idx);
        t_in_item it;
        it.operation  = op;
        it.data_byte  = b;
        it.read_index = idx;
        if ($urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        start  <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        predict_row_op(it);
        beats_sent++;
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        @(posedge i_clk);
        while (busy || pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [11:0] value);
        wait_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_MODE) begin
            cur_mode = value[1:0];
            restart_row();
        end else begin
            cur_row_bytes = 32'(value);
        end
    endtask

    task automatic put_data(input logic [7:0] b);
        send_item(OP_DATA, b, '0);
    endtask

    task automatic test_reset_state();
        send_item(OP_READ, '0, 11'd0);
        send_item(OP_READ, '1, 11'd2047);
        send_item(OP_END, '0, '0);
    endtask

    task automatic test_raw_mode();
        write_reg(CFG_ROW, 12'd3);
        write_reg(CFG_MODE, 12'(MODE_RAW));
        put_data(8'h00);
        put_data(8'hFF);
        put_data(8'hA5);
        put_data(8'h5A);
        send_item(OP_END, '0, '0);
        send_item(OP_READ, '0, 11'd1);
    endtask

    task automatic test_run_mode();
        write_reg(CFG_ROW, 12'd4095);
        write_reg(CFG_MODE, 12'(MODE_RUN));
        put_data(8'd2);
        put_data(8'hC3);
        put_data(8'd7);
        send_item(OP_END, '0, '0);
        send_item(OP_READ, '0, 11'd2);
    endtask

    task automatic test_packbits_mode();
        write_reg(CFG_ROW, 12'd16);
        write_reg(CFG_MODE, 12'(MODE_PACK));
        put_data(8'd1);
        put_data(8'h11);
        put_data(8'h22);
        put_data(8'd128);
        put_data(8'd254);
        put_data(8'h33);
        put_data(8'd129);
        send_item(OP_END, '0, '0);
    endtask

    task automatic test_delta_mode();
        write_reg(CFG_MODE, 12'(MODE_DELTA));
        put_data(8'h3F);
        put_data(8'hFF);
        send_item(OP_END, '0, '0);
        send_item(OP_CLEAR, '0, '0);
        put_data(8'h22);
        put_data(8'h99);
        send_item(OP_READ, '0, 11'd2);
    endtask

    task automatic pick_row_bytes();
        case ($urandom_range(0, 11))
            0:       write_reg(CFG_ROW, 12'd0);
            1:       write_reg(CFG_ROW, 12'd2048);
            2:       write_reg(CFG_ROW, 12'd4095);
            3:       write_reg(CFG_ROW, 12'($urandom_range(0, 2048)));
            default: write_reg(CFG_ROW, 12'($urandom_range(1, 64)));
        endcase
    endtask

    task automatic random_construct();
        logic [7:0] b;
        int n;
        case (cur_mode)
            MODE_RAW: begin
                repeat ($urandom_range(1, 6)) put_data(8'($urandom));
            end
            MODE_RUN: begin
                put_data(($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(0, 15)));
                if ($urandom_range(0, 9) != 0) put_data(8'($urandom));
            end
            MODE_PACK: begin
                case ($urandom_range(0, 2))
                    0: begin
                        b = ($urandom_range(0, 15) == 0) ? 8'($urandom_range(0, 127))
                                                         : 8'($urandom_range(0, 5));
                        put_data(b);
                        n = b + 1;
                        if ($urandom_range(0, 9) == 0) n = $urandom_range(0, n);
                        repeat (n) put_data(8'($urandom));
                    end
                    1: begin
                        put_data(8'($urandom_range(129, 255)));
                        put_data(8'($urandom));
                    end
                    default: put_data(8'd128);
                endcase
            end
            default: begin
                b = 8'($urandom);
                if ($urandom_range(0, 3) == 0) b[4:0] = 5'd31;
                put_data(b);
                if (b[4:0] == 5'd31) begin
                    while ($urandom_range(0, 1) == 0) put_data(8'hFF);
                    put_data(8'($urandom_range(0, 254)));
                end
                n = b[7:5] + 1;
                if ($urandom_range(0, 9) == 0) n = $urandom_range(0, n);
                repeat (n) put_data(8'($urandom));
            end
        endcase
    endtask

    task automatic random_read();
        send_item(OP_READ, 8'($urandom),
                  ($urandom_range(0, 3) == 0) ? 11'($urandom) : 11'($urandom_range(0, 70)));
    endtask

    task automatic test_random_rows(input int pct, input int budget);
        int stop_at;
        idle_pct = pct;
        stop_at  = beats_sent + budget;
        while (beats_sent < stop_at) begin
            if ($urandom_range(0, 3) == 0) pick_row_bytes();
            if ($urandom_range(0, 2) == 0) write_reg(CFG_MODE, 12'($urandom_range(0, 3)));
            repeat ($urandom_range(1, 4)) random_construct();
            if ($urandom_range(0, 7) == 0)
                send_item(2'($urandom), 8'($urandom), 11'($urandom));
            if ($urandom_range(0, 1) == 0) random_read();
            if ($urandom_range(0, 9) == 0) send_item(OP_CLEAR, 8'($urandom), '0);
            send_item(OP_END, 8'($urandom), 11'($urandom));
            repeat ($urandom_range(0, 2)) random_read();
        end
    endtask

    initial begin
        errors        = 0;
        beats_sent    = 0;
        results_seen  = 0;
        idle_pct      = 0;
        cycles        = 0;
        cur_mode      = MODE_RAW;
        cur_row_bytes = 0;
        row_cnt       = 0;
        row_void      = 1'b1;
        foreach (seed_copy[k]) seed_copy[k] = '0;
        restart_row();
        i_rst_n     <= 1'b0;
        start       <= 1'b0;
        i_item      <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= 1'b0;
        i_cfg_data  <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_state();
        test_raw_mode();
        test_run_mode();
        test_packbits_mode();
        test_delta_mode();
        test_random_rows(13, 200);
        test_random_rows(59, 200);
        test_random_rows(0, 200);

        wait_idle();
        repeat (20) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            $display("%0d expected results never arrived", pending_results.size());
            errors++;
        end
        $display("Sent %0d beats in all four modes, checked %0d results, %0d errors.",
                 beats_sent, results_seen, errors);
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

>>> filelist.f
rtl/rrd_pkg.sv
rtl/rrd_seed_mem.sv
rtl/raster_row_decompressor.sv
rtl/rrd_checker.sv
tb/raster_row_decompressor_tb.sv
